/* rtl/core/bdq_pkg.sv */
// ----------------------------------------------------------------------------
// bdq_pkg: shared types and codes of the bounded deque
// Command, status and cell operation codes used by the cell chain and the top.
// ----------------------------------------------------------------------------
`default_nettype none

package bdq_pkg;

	localparam int DataW      = 32;
	localparam int CmdW       = 3;
	localparam int StatusW    = 2;
	localparam int MaxResults = 32;

	localparam logic [CmdW-1:0] CMD_PUSH_FRONT = 3'd0;
	localparam logic [CmdW-1:0] CMD_PUSH_BACK  = 3'd1;
	localparam logic [CmdW-1:0] CMD_POP_FRONT  = 3'd2;
	localparam logic [CmdW-1:0] CMD_POP_BACK   = 3'd3;
	localparam logic [CmdW-1:0] CMD_DUMP       = 3'd4;

	localparam logic [StatusW-1:0] STATUS_OK    = 2'd0;
	localparam logic [StatusW-1:0] STATUS_EMPTY = 2'd1;
	localparam logic [StatusW-1:0] STATUS_FULL  = 2'd2;

	// Operation that every cell of the chain performs.
	typedef enum logic [2:0] {
		OP_HOLD       = 3'd0,
		OP_PUSH_FRONT = 3'd1,
		OP_PUSH_BACK  = 3'd2,
		OP_POP_FRONT  = 3'd3,
		OP_POP_BACK   = 3'd4,
		OP_ROTATE     = 3'd5
	} cell_op_t;

	// Control broadcast to all cells.
	typedef struct packed {
		cell_op_t          op;
		logic [DataW-1:0]  value;
	} cell_ctrl_t;

endpackage

`default_nettype wire

/* rtl/core/bdq_cell.sv */
// ----------------------------------------------------------------------------
// bdq_cell: one storage cell of the deque chain
// Holds one word and an occupied flag; shifts toward either neighbor.
// ----------------------------------------------------------------------------
`default_nettype none

module bdq_cell (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire bdq_pkg::cell_ctrl_t         ctrl,
	input  wire logic [bdq_pkg::DataW-1:0]   left_data,
	input  wire logic                        left_occ,
	input  wire logic [bdq_pkg::DataW-1:0]   right_data,
	input  wire logic                        right_occ,
	input  wire logic [bdq_pkg::DataW-1:0]   front_data,
	output logic      [bdq_pkg::DataW-1:0]   data_q,
	output logic                             occ_q,
	output logic      [bdq_pkg::DataW-1:0]   tail_data
);

	logic is_tail;
	logic is_first_free;
	logic occ_d;
	logic [bdq_pkg::DataW-1:0] data_d;
	logic data_en;

	// The occupied cells form a solid run starting at cell zero.
	assign is_tail       = occ_q & ~right_occ;
	assign is_first_free = ~occ_q & left_occ;
	assign tail_data     = is_tail ? data_q : '0;

	always_comb begin
		occ_d   = occ_q;
		data_d  = data_q;
		data_en = 1'b0;
		case (ctrl.op)
			bdq_pkg::OP_PUSH_FRONT: begin
				occ_d   = left_occ;
				data_d  = left_data;
				data_en = 1'b1;
			end
			bdq_pkg::OP_PUSH_BACK: begin
				if (is_first_free) begin
					occ_d   = 1'b1;
					data_d  = ctrl.value;
					data_en = 1'b1;
				end
			end
			bdq_pkg::OP_POP_FRONT: begin
				occ_d   = right_occ;
				data_d  = right_data;
				data_en = 1'b1;
			end
			bdq_pkg::OP_POP_BACK: begin
				if (is_tail) begin
					occ_d = 1'b0;
				end
			end
			bdq_pkg::OP_ROTATE: begin
				data_d  = is_tail ? front_data : right_data;
				data_en = 1'b1;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q <= 1'b0;
		end else begin
			occ_q <= occ_d;
		end
	end

	always_ff @(posedge clk) begin
		if (data_en) begin
			data_q <= data_d;
		end
	end

endmodule

`default_nettype wire

/* rtl/core/bounded_deque.sv */
// ----------------------------------------------------------------------------
// bounded_deque: double-ended queue of signed words, DEPTH entries deep
// Push and pop: the result is registered in the cycle after the command is taken.
// Dump: one rotation of the cell chain per stored entry; a rotation that gives
// a result waits while the output register holds one not yet taken.
// Reset clears the occupied flags and count; stored words are not reset.
// ----------------------------------------------------------------------------
`default_nettype none

// The queue is a chain of cells with the front entry always in cell zero and
// the occupied cells forming one solid run. A push at the front shifts the
// whole chain one cell back; a pop at the front shifts it one cell forward.
// The back end is the last occupied cell: a push at the back fills the first
// free cell, and a pop at the back clears the tail cell's flag and returns its
// word, gathered by an OR over the cells (only the tail cell drives nonzero).
//
// A dump rotates the chain once per cycle unless stalled: cell zero is
// presented as a result and its word moves into the tail cell while the rest
// shift forward. After as many rotations as there are entries, the original
// order is restored. When DEPTH exceeds the result limit, the rotations beyond
// the limit run silently so the order still comes back. Input is taken only
// when no dump is in progress and the output register is free or being emptied.

module bounded_deque #(
	parameter int DEPTH = 32
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              in_valid,
	output logic                                   in_ready,
	input  wire logic        [bdq_pkg::CmdW-1:0]   cmd,
	input  wire logic signed [bdq_pkg::DataW-1:0]  value,
	output logic                                   out_valid,
	input  wire logic                              out_ready,
	output logic signed      [bdq_pkg::DataW-1:0]  data,
	output logic             [bdq_pkg::StatusW-1:0] status,
	output logic                                   last
);

	localparam int CntW = $clog2(DEPTH + 1);
	// Comparison width wide enough for both the count and the result limit.
	localparam int IdxW = (CntW > $clog2(bdq_pkg::MaxResults + 1)) ?
		CntW : $clog2(bdq_pkg::MaxResults + 1);
	localparam logic [CntW-1:0] FullCount = CntW'(DEPTH);
	localparam logic [IdxW-1:0] MaxIdx    = IdxW'(bdq_pkg::MaxResults);

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_DUMP = 2'b10
	} state_t;

	state_t state_q;
	logic [CntW-1:0] cnt_q;
	logic [CntW-1:0] dump_idx_q;

	logic                         out_valid_q;
	logic [bdq_pkg::DataW-1:0]    data_q;
	logic [bdq_pkg::StatusW-1:0]  status_q;
	logic                         last_q;

	bdq_pkg::cell_ctrl_t ctrl;

	logic [bdq_pkg::DataW-1:0] cell_data [DEPTH];
	logic [bdq_pkg::DataW-1:0] cell_tail [DEPTH];
	logic [DEPTH-1:0]          occ;
	logic [bdq_pkg::DataW-1:0] back_data;

	logic out_free;
	logic in_fire;
	logic is_full;
	logic is_empty;
	logic dump_emit;
	logic dump_step;
	logic dump_last;
	logic dump_done;
	logic [IdxW-1:0] idx_ext;
	logic [IdxW-1:0] cnt_ext;
	logic [IdxW-1:0] emit_n;

	assign out_free = ~out_valid_q | out_ready;
	assign in_ready = (state_q == ST_IDLE) & out_free;
	assign in_fire  = in_valid & in_ready;
	assign is_full  = (cnt_q == FullCount);
	assign is_empty = (cnt_q == '0);

	// Dump bookkeeping: results are given only for the first MaxResults
	// rotations; last marks the final result given.
	assign idx_ext   = IdxW'(dump_idx_q);
	assign cnt_ext   = IdxW'(cnt_q);
	assign emit_n    = (cnt_ext > MaxIdx) ? MaxIdx : cnt_ext;
	assign dump_emit = (idx_ext < MaxIdx);
	assign dump_last = (idx_ext == emit_n - 1'b1);
	assign dump_done = (dump_idx_q == cnt_q - 1'b1);
	assign dump_step = (state_q == ST_DUMP) & (~dump_emit | out_free);

	// Cell operation for this cycle.
	always_comb begin
		ctrl.op    = bdq_pkg::OP_HOLD;
		ctrl.value = value;
		if (dump_step) begin
			ctrl.op = bdq_pkg::OP_ROTATE;
		end else if (in_fire) begin
			case (cmd)
				bdq_pkg::CMD_PUSH_FRONT: begin
					if (!is_full) begin
						ctrl.op = bdq_pkg::OP_PUSH_FRONT;
					end
				end
				bdq_pkg::CMD_PUSH_BACK: begin
					if (!is_full) begin
						ctrl.op = bdq_pkg::OP_PUSH_BACK;
					end
				end
				bdq_pkg::CMD_POP_FRONT: begin
					if (!is_empty) begin
						ctrl.op = bdq_pkg::OP_POP_FRONT;
					end
				end
				bdq_pkg::CMD_POP_BACK: begin
					if (!is_empty) begin
						ctrl.op = bdq_pkg::OP_POP_BACK;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// The chain. Cell zero's left neighbor is the pushed word, always occupied;
	// the last cell's right neighbor is an empty cell.
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic [bdq_pkg::DataW-1:0] l_data;
		logic                      l_occ;
		logic [bdq_pkg::DataW-1:0] r_data;
		logic                      r_occ;

		if (i == 0) begin : g_first
			assign l_data = value;
			assign l_occ  = 1'b1;
		end else begin : g_mid_l
			assign l_data = cell_data[i-1];
			assign l_occ  = occ[i-1];
		end

		if (i == DEPTH - 1) begin : g_end
			assign r_data = '0;
			assign r_occ  = 1'b0;
		end else begin : g_mid_r
			assign r_data = cell_data[i+1];
			assign r_occ  = occ[i+1];
		end

		bdq_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctrl       (ctrl),
			.left_data  (l_data),
			.left_occ   (l_occ),
			.right_data (r_data),
			.right_occ  (r_occ),
			.front_data (cell_data[0]),
			.data_q     (cell_data[i]),
			.occ_q      (occ[i]),
			.tail_data  (cell_tail[i])
		);
	end

	// Only the tail cell drives a nonzero word, so an OR picks the back entry.
	always_comb begin
		back_data = '0;
		for (int k = 0; k < DEPTH; k++) begin
			back_data = back_data | cell_tail[k];
		end
	end

	// Control state: sequencer, entry count and dump position.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			cnt_q      <= '0;
			dump_idx_q <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						case (ctrl.op) inside
							bdq_pkg::OP_PUSH_FRONT,
							bdq_pkg::OP_PUSH_BACK: cnt_q <= cnt_q + 1'b1;
							bdq_pkg::OP_POP_FRONT,
							bdq_pkg::OP_POP_BACK:  cnt_q <= cnt_q - 1'b1;
							default: begin
							end
						endcase
						if (cmd == bdq_pkg::CMD_DUMP && !is_empty) begin
							state_q    <= ST_DUMP;
							dump_idx_q <= '0;
						end
					end
				end
				ST_DUMP: begin
					if (dump_step) begin
						dump_idx_q <= dump_idx_q + 1'b1;
						if (dump_done) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Output register: a new result loads whenever the slot is free or its
	// transfer completes in this cycle. A dump of a nonempty queue loads
	// nothing here; its results come from the rotation.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (dump_step) begin
			out_valid_q <= dump_emit | (out_valid_q & ~out_ready);
		end else if (in_fire) begin
			out_valid_q <= (cmd == bdq_pkg::CMD_PUSH_FRONT) |
			               (cmd == bdq_pkg::CMD_PUSH_BACK)  |
			               (cmd == bdq_pkg::CMD_POP_FRONT)  |
			               (cmd == bdq_pkg::CMD_POP_BACK)   |
			               ((cmd == bdq_pkg::CMD_DUMP) & is_empty);
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (dump_step && dump_emit) begin
			data_q   <= cell_data[0];
			status_q <= bdq_pkg::STATUS_OK;
			last_q   <= dump_last;
		end else if (in_fire) begin
			data_q <= '0;
			last_q <= 1'b1;
			case (cmd) inside
				bdq_pkg::CMD_PUSH_FRONT,
				bdq_pkg::CMD_PUSH_BACK: begin
					status_q <= is_full ? bdq_pkg::STATUS_FULL : bdq_pkg::STATUS_OK;
				end
				bdq_pkg::CMD_POP_FRONT: begin
					status_q <= is_empty ? bdq_pkg::STATUS_EMPTY : bdq_pkg::STATUS_OK;
					data_q   <= is_empty ? '0 : cell_data[0];
				end
				bdq_pkg::CMD_POP_BACK: begin
					status_q <= is_empty ? bdq_pkg::STATUS_EMPTY : bdq_pkg::STATUS_OK;
					data_q   <= is_empty ? '0 : back_data;
				end
				default: begin
					// A dump of an empty queue gives one empty result here;
					// a nonempty dump starts the rotation instead.
					status_q <= bdq_pkg::STATUS_EMPTY;
				end
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign data      = data_q;
	assign status    = status_q;
	assign last      = last_q;

	// The occupied flags always agree with the entry count.
	a_occ_matches_count: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(occ) == cnt_q)
		else $error("occupied cells disagree with entry count");

	// The occupied cells form one run starting at cell zero.
	a_occ_solid: assert property (@(posedge clk) disable iff (!arst_n)
		((occ & (occ + 1'b1)) == '0))
		else $error("occupied cells are not contiguous from the front");

	// A dump never runs on an empty queue.
	a_dump_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DUMP) |-> (cnt_q != '0))
		else $error("dump in progress with an empty queue");

	// An accepted push into a queue with room grows it by one entry.
	a_push_grows: assert property (@(posedge clk) disable iff (!arst_n)
		(in_fire && !is_full &&
		 (cmd == bdq_pkg::CMD_PUSH_FRONT || cmd == bdq_pkg::CMD_PUSH_BACK))
		|=> (cnt_q == $past(cnt_q) + 1'b1))
		else $error("push did not grow the queue");

endmodule

`default_nettype wire
